// File: sv/npc_pkg.sv
// Shared constants for the nearest palette color block: field widths,
// command codes and result status codes. No dependencies.
package npc_pkg;

	localparam int FUNC_W   = 2;
	localparam int COLOR_W  = 8;
	localparam int INDEX_W  = 4;
	localparam int DIST_W   = 18;
	localparam int STATUS_W = 3;
	localparam int RGB_W    = 3 * COLOR_W;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_MAPPED  = 3'd0;
	localparam status_t ST_LOADED  = 3'd1;
	localparam status_t ST_CLEARED = 3'd2;
	localparam status_t ST_EMPTY   = 3'd3;
	localparam status_t ST_DROPPED = 3'd4;

endpackage

// File: sv/npc_req_if.sv
// Request channel of the nearest palette color block: valid/ready plus
// command and RGB payload. Depends on npc_pkg.
interface npc_req_if;
	logic                         valid;
	logic                         ready;
	logic [npc_pkg::FUNC_W-1:0]  func;
	logic [npc_pkg::COLOR_W-1:0] red;
	logic [npc_pkg::COLOR_W-1:0] green;
	logic [npc_pkg::COLOR_W-1:0] blue;

	modport source (output valid, func, red, green, blue, input ready);
	modport sink (input valid, func, red, green, blue, output ready);
endinterface

// File: sv/npc_rsp_if.sv
// Response channel of the nearest palette color block: valid/ready plus
// chosen color, index, distance and status. Depends on npc_pkg.
interface npc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [npc_pkg::COLOR_W-1:0]   out_red;
	logic [npc_pkg::COLOR_W-1:0]   out_green;
	logic [npc_pkg::COLOR_W-1:0]   out_blue;
	logic [npc_pkg::INDEX_W-1:0]   entry_index;
	logic [npc_pkg::DIST_W-1:0]    best_distance_sq;
	logic [npc_pkg::STATUS_W-1:0]  status;

	modport source (output valid, out_red, out_green, out_blue, entry_index,
		best_distance_sq, status, input ready);
	modport sink (input valid, out_red, out_green, out_blue, entry_index,
		best_distance_sq, status, output ready);
endinterface

// File: sv/npc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module npc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/nearest_palette_color.sv
// Nearest palette color quantizer, RGB888. Depends on npc_pkg, npc_req_if,
// npc_rsp_if and npc_ram.
//
// A clear or a load word, and a map on an empty palette, is answered
// straight into the output register, and is taken only while that register is
// free. A map word on a palette of loaded entries is scanned from the newest
// entry to the oldest: the palette RAM delivers one entry per cycle to a
// distance stage and a compare stage, and the result goes to the output
// register once the last entry is compared and that register is free. No
// new word is taken before then. Up to PALETTE_ENTRIES colors are held;
// a load into a full palette is dropped and flagged. On equal distance the
// most recently loaded entry wins. A map word on a non-empty palette is
// taken even while the previous result still waits in the output register;
// every other word waits until that register is free.
module nearest_palette_color #(
	parameter int PALETTE_ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	npc_req_if.sink   req,
	npc_rsp_if.source rsp
);

	import npc_pkg::*;

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int CW = $clog2(PALETTE_ENTRIES + 1);
	localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_SEND
	} state_t;

	state_t state_q;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_m1;
	logic [COLOR_W-1:0] px_r_q, px_g_q, px_b_q;
	logic [AW-1:0]      scan_idx_q;

	logic               rd_vld_s1, rd_first_s1, rd_last_s1;
	logic [AW-1:0]      rd_idx_s1;

	logic               vld_s2, first_s2, last_s2;
	logic [AW-1:0]      idx_s2;
	logic [RGB_W-1:0]   color_s2;
	logic [DIST_W-1:0]  dist_s2;

	logic [AW-1:0]      best_idx_q;
	logic [RGB_W-1:0]   best_color_q;
	logic [DIST_W-1:0]  best_dist_q;

	logic               rsp_valid_q;
	logic [COLOR_W-1:0] rsp_r_q, rsp_g_q, rsp_b_q;
	logic [INDEX_W-1:0] rsp_idx_q;
	logic [DIST_W-1:0]  rsp_dist_q;
	status_t            rsp_status_q;

	logic               out_free;
	logic               accept;
	logic               is_map;
	logic               full;
	logic               rsp_load;
	logic               ram_we;
	logic [RGB_W-1:0]   ram_wdata;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [RGB_W-1:0]   ram_rdata;

	logic [COLOR_W-1:0] dr, dg, db;
	logic [2*COLOR_W-1:0] sq_r, sq_g, sq_b;
	logic [DIST_W-1:0]  dist_sum;
	logic               take;
	logic [IW-1:0]      best_idx_ext;
	logic [IW-1:0]      wr_idx_ext;

	assign count_m1  = count_q - CW'(1);
	assign full      = (count_q == CW'(PALETTE_ENTRIES));
	assign is_map    = req.func[1];
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE)
		&& (out_free || (is_map && (count_q != '0)));
	assign accept    = req.valid && req.ready;
	assign rsp_load  = ((state_q == S_IDLE) && accept && !(is_map && (count_q != '0)))
		|| ((state_q == S_SEND) && out_free);

	assign ram_we    = accept && (req.func == FUNC_LOAD) && !full;
	assign ram_waddr = count_q[AW-1:0];
	assign ram_wdata = {req.red, req.green, req.blue};
	assign ram_raddr = scan_idx_q;

	npc_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		dr = (ram_rdata[23:16] > px_r_q) ? ram_rdata[23:16] - px_r_q
			: px_r_q - ram_rdata[23:16];
		dg = (ram_rdata[15:8] > px_g_q) ? ram_rdata[15:8] - px_g_q
			: px_g_q - ram_rdata[15:8];
		db = (ram_rdata[7:0] > px_b_q) ? ram_rdata[7:0] - px_b_q
			: px_b_q - ram_rdata[7:0];
		sq_r = (2*COLOR_W)'(dr) * (2*COLOR_W)'(dr);
		sq_g = (2*COLOR_W)'(dg) * (2*COLOR_W)'(dg);
		sq_b = (2*COLOR_W)'(db) * (2*COLOR_W)'(db);
		dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
	end

	assign take         = first_s2 || (dist_s2 < best_dist_q);
	assign best_idx_ext = IW'(best_idx_q);
	assign wr_idx_ext   = IW'(count_q[AW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			vld_s2      <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			// read issue
			rd_vld_s1   <= (state_q == S_SCAN);
			rd_idx_s1   <= scan_idx_q;
			rd_first_s1 <= (scan_idx_q == count_m1[AW-1:0]);
			rd_last_s1  <= (scan_idx_q == '0);

			// distance stage
			vld_s2   <= rd_vld_s1;
			first_s2 <= rd_first_s1;
			last_s2  <= rd_last_s1;
			idx_s2   <= rd_idx_s1;
			color_s2 <= ram_rdata;
			dist_s2  <= dist_sum;

			// compare stage
			if (vld_s2 && take) begin
				best_idx_q   <= idx_s2;
				best_color_q <= color_s2;
				best_dist_q  <= dist_s2;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_map && (count_q != '0)) begin
							px_r_q     <= req.red;
							px_g_q     <= req.green;
							px_b_q     <= req.blue;
							scan_idx_q <= count_m1[AW-1:0];
							state_q    <= S_SCAN;
						end else begin
							rsp_r_q     <= '0;
							rsp_g_q     <= '0;
							rsp_b_q     <= '0;
							rsp_dist_q  <= '0;
							if (is_map) begin
								rsp_status_q <= ST_EMPTY;
								rsp_idx_q    <= '0;
							end else if (req.func == FUNC_CLEAR) begin
								rsp_status_q <= ST_CLEARED;
								rsp_idx_q    <= '0;
								count_q      <= '0;
							end else if (full) begin
								rsp_status_q <= ST_DROPPED;
								rsp_idx_q    <= '0;
							end else begin
								rsp_status_q <= ST_LOADED;
								rsp_idx_q    <= wr_idx_ext[INDEX_W-1:0];
								count_q      <= count_q + CW'(1);
							end
						end
					end
				end
				S_SCAN: begin
					if (scan_idx_q == '0) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q - AW'(1);
					end
				end
				S_DRAIN: begin
					if (vld_s2 && last_s2) begin
						state_q <= S_SEND;
					end
				end
				S_SEND: begin
					if (out_free) begin
						rsp_r_q      <= best_color_q[23:16];
						rsp_g_q      <= best_color_q[15:8];
						rsp_b_q      <= best_color_q[7:0];
						rsp_idx_q    <= best_idx_ext[INDEX_W-1:0];
						rsp_dist_q   <= best_dist_q;
						rsp_status_q <= ST_MAPPED;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.out_red          = rsp_r_q;
	assign rsp.out_green        = rsp_g_q;
	assign rsp.out_blue         = rsp_b_q;
	assign rsp.entry_index      = rsp_idx_q;
	assign rsp.best_distance_sq = rsp_dist_q;
	assign rsp.status           = rsp_status_q;

endmodule

// File: dv/palette_checker.sv
// Checker for the nearest palette color block: mirrors the palette, works out
// each response word from the accepted request words and compares field by field.
// Depends on npc_pkg, npc_req_if and npc_rsp_if.
module palette_checker #(
	parameter int PALETTE_ENTRIES = 16
) (
	input  logic clk,
	input  logic arst_n,
	npc_req_if   req,
	npc_rsp_if   rsp,
	output int   mismatches,
	output int   pending,
	output int   results_seen,
	output int   maps_seen,
	output int   drops_seen,
	output int   empties_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import npc_pkg::*;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [INDEX_W-1:0] entry_index;
		logic [DIST_W-1:0]  distance_sq;
		status_t            status;
	} quant_word_t;

	logic [RGB_W-1:0] palette [PALETTE_ENTRIES];
	int               loaded_count;
	quant_word_t      quant_q [$];

	initial begin
		loaded_count = 0;
		mismatches   = 0;
		pending      = 0;
		results_seen = 0;
		maps_seen    = 0;
		drops_seen   = 0;
		empties_seen = 0;
	end

	function automatic int unsigned sq_gap(input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] b);
		int diff;
		diff = int'(a) - int'(b);
		return diff * diff;
	endfunction

	function automatic quant_word_t quantize(input logic [FUNC_W-1:0] f,
		input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
		input logic [COLOR_W-1:0] b);
		quant_word_t      w;
		logic [RGB_W-1:0] c;
		int unsigned      d;
		int unsigned      best_d;
		int               best_i;
		int               i;
		w = '0;
		if (f == FUNC_CLEAR) begin
			loaded_count = 0;
			w.status = ST_CLEARED;
		end else if (f == FUNC_LOAD) begin
			if (loaded_count >= PALETTE_ENTRIES) begin
				w.status = ST_DROPPED;
			end else begin
				palette[loaded_count] = {r, g, b};
				w.entry_index = INDEX_W'(loaded_count);
				w.status = ST_LOADED;
				loaded_count++;
			end
		end else if (loaded_count == 0) begin
			w.status = ST_EMPTY;
		end else begin
			// scan newest to oldest, keep only a strictly closer entry
			best_d = '1;
			best_i = 0;
			for (i = loaded_count - 1; i >= 0; i--) begin
				c = palette[i];
				d = sq_gap(c[23:16], r) + sq_gap(c[15:8], g) + sq_gap(c[7:0], b);
				if (d < best_d) begin
					best_d = d;
					best_i = i;
				end
			end
			c = palette[best_i];
			{w.red, w.green, w.blue} = c;
			w.entry_index = INDEX_W'(best_i);
			w.distance_sq = DIST_W'(best_d);
			w.status = ST_MAPPED;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input longint got,
		input longint want);
		mismatches++;
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		quant_word_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				want = quantize(req.func, req.red, req.green, req.blue);
				quant_q.push_back(want);
				case (want.status)
					ST_MAPPED:  maps_seen++;
					ST_DROPPED: drops_seen++;
					ST_EMPTY:   empties_seen++;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (quant_q.size() == 0) begin
					report_mismatch("word with nothing pending", rsp.status, 0);
				end else begin
					want = quant_q.pop_front();
					if (rsp.out_red !== want.red)
						report_mismatch("out_red", rsp.out_red, want.red);
					if (rsp.out_green !== want.green)
						report_mismatch("out_green", rsp.out_green, want.green);
					if (rsp.out_blue !== want.blue)
						report_mismatch("out_blue", rsp.out_blue, want.blue);
					if (rsp.entry_index !== want.entry_index)
						report_mismatch("entry_index", rsp.entry_index, want.entry_index);
					if (rsp.best_distance_sq !== want.distance_sq)
						report_mismatch("best_distance_sq", rsp.best_distance_sq,
							want.distance_sq);
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
				end
			end
			pending = quant_q.size();
		end
	end

endmodule

// File: dv/testbench.sv
// Top of the nearest palette color testbench: clock, reset, request words and
// response stalls, with palette_checker beside the block giving the verdict.
// Depends on npc_pkg, npc_req_if, npc_rsp_if, palette_checker and the block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import npc_pkg::*;

	localparam int PALETTE_ENTRIES = 16;
	localparam int ITEMS           = 1400;

	localparam logic [FUNC_W-1:0] FUNC_MAP     = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_MAP_ALT = 2'd3;

	logic clk;
	logic arst_n;
	bit   steady;
	int   sent;
	int   shade_count;

	logic [RGB_W-1:0] shade [PALETTE_ENTRIES];

	int mismatches;
	int pending;
	int results_seen;
	int maps_seen;
	int drops_seen;
	int empties_seen;

	npc_req_if req_bus ();
	npc_rsp_if rsp_bus ();

	nearest_palette_color #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	palette_checker #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_bus),
		.rsp          (rsp_bus),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.maps_seen    (maps_seen),
		.drops_seen   (drops_seen),
		.empties_seen (empties_seen)
	);

	initial clk = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 24);
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [COLOR_W-1:0] nudge(input logic [COLOR_W-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 16)) - 8;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return COLOR_W'(v);
	endfunction

	function automatic logic [RGB_W-1:0] pick_pixel();
		logic [RGB_W-1:0] base;
		int unsigned      roll;
		roll = $urandom_range(0, 99);
		if (shade_count == 0 || roll < 40)
			return RGB_W'($urandom);
		base = shade[$urandom_range(0, shade_count - 1)];
		if (roll < 55)
			return base;
		if (roll < 90)
			return {nudge(base[23:16]), nudge(base[15:8]), nudge(base[7:0])};
		return {{COLOR_W{1'($urandom_range(0, 1))}}, {COLOR_W{1'($urandom_range(0, 1))}},
			{COLOR_W{1'($urandom_range(0, 1))}}};
	endfunction

	task automatic send_word(input logic [FUNC_W-1:0] f, input logic [RGB_W-1:0] rgb);
		while (!steady && $urandom_range(0, 99) < 24) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.func  <= f;
		{req_bus.red, req_bus.green, req_bus.blue} <= rgb;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		sent++;
		if (f == FUNC_CLEAR) begin
			shade_count = 0;
		end else if (f == FUNC_LOAD && shade_count < PALETTE_ENTRIES) begin
			shade[shade_count] = rgb;
			shade_count++;
		end
	endtask

	// hold the sender until every response word is back
	task automatic drain();
		req_bus.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_segment();
		logic [RGB_W-1:0] rgb;
		int               n_loads;
		if ($urandom_range(0, 99) < 5)
			drain();
		if ($urandom_range(0, 99) < 75) begin
			send_word(FUNC_CLEAR, RGB_W'($urandom));
			n_loads = ($urandom_range(0, 99) < 25) ? $urandom_range(15, 20)
				: $urandom_range(1, 16);
			repeat (n_loads) begin
				if (shade_count > 0 && $urandom_range(0, 3) == 0)
					rgb = shade[$urandom_range(0, shade_count - 1)];
				else
					rgb = RGB_W'($urandom);
				send_word(FUNC_LOAD, rgb);
			end
			repeat ($urandom_range(1, 14))
				send_word(($urandom_range(0, 9) == 0) ? FUNC_MAP_ALT : FUNC_MAP, pick_pixel());
		end else begin
			repeat ($urandom_range(1, 8))
				send_word(FUNC_W'($urandom), RGB_W'($urandom));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		steady        = 1'b0;
		sent          = 0;
		shade_count   = 0;
		req_bus.valid = 1'b0;
		req_bus.func  = FUNC_CLEAR;
		req_bus.red   = '0;
		req_bus.green = '0;
		req_bus.blue  = '0;
		rsp_bus.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(FUNC_MAP, 24'h123456);
		send_word(FUNC_LOAD, 24'h000000);
		send_word(FUNC_LOAD, 24'hFFFFFF);
		send_word(FUNC_MAP, 24'h000000);
		send_word(FUNC_MAP, 24'hFFFFFF);
		send_word(FUNC_MAP, 24'h808080);
		send_word(FUNC_CLEAR, 24'h5A5A5A);
		send_word(FUNC_MAP, 24'hFF00FF);
		send_word(FUNC_LOAD, 24'h000000);
		send_word(FUNC_MAP, 24'hFFFFFF);
		send_word(FUNC_LOAD, 24'h000000);
		send_word(FUNC_MAP, 24'h010101);
		send_word(FUNC_MAP_ALT, 24'h000000);
		send_word(FUNC_LOAD, 24'hAA5533);
		send_word(FUNC_MAP_ALT, 24'h55AACC);
		send_word(FUNC_MAP, 24'hA95634);
		drain();

		while (sent < ITEMS) begin
			steady = (sent >= 500 && sent < 750);
			run_segment();
		end
		steady = 1'b0;

		drain();
		repeat (PALETTE_ENTRIES + 8) @(posedge clk);

		$display("Sent %0d words; checked %0d response words.", sent, results_seen);
		$display("Covered %0d maps, %0d empty-palette maps and %0d dropped loads.",
			maps_seen, empties_seen, drops_seen);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
sv/npc_pkg.sv
sv/npc_req_if.sv
sv/npc_rsp_if.sv
sv/npc_ram.sv
sv/nearest_palette_color.sv
dv/palette_checker.sv
dv/testbench.sv
